// ===== rtl/core/g1lc_pkg.sv =====
package g1lc_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int POS_W      = 32;
	localparam int LBL_W      = 7;
	localparam int LIM_W      = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = LIM_W;

	localparam logic [LBL_W-1:0]      LBL_UNASSIGNED = {LBL_W{1'b1}};
	localparam logic [LIM_W-1:0]      LIMIT_RESET    = LIM_W'(6554);
	localparam logic [CFG_IDX_W-1:0]  REG_DISTANCE_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0]  REG_SEED_ASCENDING = CFG_IDX_W'(1);

	typedef struct packed {
		logic [LIM_W-1:0] distance_limit;
		logic             seed_ascending;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [LBL_W-1:0] label;
		logic             final_beat;
	} emit_t;

endpackage

// ===== rtl/core/g1lc_ram.sv =====
module g1lc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/g1lc_dist.sv =====
module g1lc_dist (
	input  logic signed [g1lc_pkg::POS_W-1:0] point,
	input  logic signed [g1lc_pkg::POS_W-1:0] seed,
	input  logic        [g1lc_pkg::LIM_W-1:0] limit,
	output logic                              near
);
	import g1lc_pkg::*;

	logic signed [POS_W:0] fwd;
	logic signed [POS_W:0] rev;
	logic        [POS_W:0] mag;

	assign fwd  = {point[POS_W-1], point} - {seed[POS_W-1], seed};
	assign rev  = {seed[POS_W-1], seed} - {point[POS_W-1], point};
	assign mag  = fwd[POS_W] ? unsigned'(rev) : unsigned'(fwd);
	assign near = mag < {{(POS_W + 1 - LIM_W){1'b0}}, limit};

endmodule

// ===== rtl/core/g1lc_seq.sv =====
module g1lc_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [g1lc_pkg::POS_W-1:0] position,
	input  logic signed [g1lc_pkg::LBL_W-1:0] preset_label,
	input  logic                              last_point,
	input  g1lc_pkg::cfg_t                    cfg,
	input  logic                              out_free,
	output g1lc_pkg::emit_t                   emit
);
	import g1lc_pkg::*;

	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_SEED_RD  = 3'd1;
	localparam logic [2:0] ST_SEED_CHK = 3'd2;
	localparam logic [2:0] ST_SCAN     = 3'd3;
	localparam logic [2:0] ST_EMIT_RD  = 3'd4;
	localparam logic [2:0] ST_EMIT_CAP = 3'd5;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        point_count_q;
	logic [LBL_W-1:0]        next_tag_q;
	logic [IDX_W-1:0]        seed_index_q;
	logic [IDX_W-1:0]        scan_index_q;
	logic signed [POS_W-1:0] seed_pos_q;

	logic                    store_full;
	logic                    in_beat;
	logic [CNT_W-1:0]        count_inc;
	logic [CNT_W-1:0]        last_idx;
	logic                    asc;

	logic [IDX_W-1:0]        raddr;
	logic                    pos_we;
	logic                    lbl_we;
	logic [IDX_W-1:0]        lbl_waddr;
	logic [LBL_W-1:0]        lbl_wdata;
	logic [POS_W-1:0]        pos_rdata;
	logic [LBL_W-1:0]        lbl_rdata;
	logic                    near;

	logic [IDX_W-1:0]        first_scan;
	logic                    has_scan;
	logic [IDX_W-1:0]        next_scan;
	logic                    scan_last;
	logic                    seed_last;
	logic [IDX_W-1:0]        next_seed;
	logic                    seed_free;
	logic                    emit_last;

	assign asc        = cfg.seed_ascending;
	assign store_full = point_count_q == CNT_W'(MAX_POINTS);
	assign in_ready   = state_q == ST_LOAD;
	assign in_beat    = in_valid && in_ready;
	assign count_inc  = store_full ? point_count_q : point_count_q + CNT_W'(1);
	assign last_idx   = point_count_q - CNT_W'(1);

	assign first_scan = asc ? seed_index_q + IDX_W'(1) : seed_index_q - IDX_W'(1);
	assign has_scan   = asc ? ({1'b0, seed_index_q} != last_idx) : (seed_index_q != '0);
	assign next_scan  = asc ? scan_index_q + IDX_W'(1) : scan_index_q - IDX_W'(1);
	assign scan_last  = asc ? ({1'b0, scan_index_q} == last_idx) : (scan_index_q == '0);
	assign seed_last  = asc ? ({1'b0, seed_index_q} == last_idx) : (seed_index_q == '0);
	assign next_seed  = asc ? seed_index_q + IDX_W'(1) : seed_index_q - IDX_W'(1);
	assign seed_free  = lbl_rdata == LBL_UNASSIGNED;
	assign emit_last  = {1'b0, seed_index_q} == last_idx;

	always_comb begin
		unique case (state_q)
			ST_SEED_CHK: raddr = first_scan;
			ST_SCAN:     raddr = next_scan;
			default:     raddr = seed_index_q;
		endcase
	end

	always_comb begin
		pos_we    = 1'b0;
		lbl_we    = 1'b0;
		lbl_waddr = seed_index_q;
		lbl_wdata = next_tag_q;
		unique case (state_q)
			ST_LOAD: begin
				pos_we    = in_beat && !store_full;
				lbl_we    = in_beat && !store_full;
				lbl_waddr = point_count_q[IDX_W-1:0];
				lbl_wdata = preset_label;
			end
			ST_SEED_CHK: begin
				lbl_we = seed_free;
			end
			ST_SCAN: begin
				lbl_we    = seed_free && near;
				lbl_waddr = scan_index_q;
			end
			default: begin
				lbl_we = 1'b0;
			end
		endcase
	end

	g1lc_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (point_count_q[IDX_W-1:0]),
		.wdata (position),
		.raddr (raddr),
		.rdata (pos_rdata)
	);

	g1lc_ram #(.WIDTH(LBL_W), .DEPTH(MAX_POINTS)) u_lbl_ram (
		.clk   (clk),
		.we    (lbl_we),
		.waddr (lbl_waddr),
		.wdata (lbl_wdata),
		.raddr (raddr),
		.rdata (lbl_rdata)
	);

	g1lc_dist u_dist (
		.point (signed'(pos_rdata)),
		.seed  (seed_pos_q),
		.limit (cfg.distance_limit),
		.near  (near)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_SEED_CHK) begin
			seed_pos_q <= signed'(pos_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			point_count_q <= '0;
			next_tag_q    <= '0;
			seed_index_q  <= '0;
			scan_index_q  <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_beat) begin
						point_count_q <= count_inc;
						if (last_point) begin
							next_tag_q   <= '0;
							seed_index_q <= asc ? '0 : IDX_W'(count_inc - CNT_W'(1));
							state_q      <= ST_SEED_RD;
						end
					end
				end
				ST_SEED_RD: begin
					state_q <= ST_SEED_CHK;
				end
				ST_SEED_CHK: begin
					if (seed_free && has_scan) begin
						scan_index_q <= first_scan;
						state_q      <= ST_SCAN;
					end else begin
						if (seed_free) begin
							next_tag_q <= next_tag_q + LBL_W'(1);
						end
						if (seed_last) begin
							seed_index_q <= '0;
							state_q      <= ST_EMIT_RD;
						end else begin
							seed_index_q <= next_seed;
							state_q      <= ST_SEED_RD;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						next_tag_q <= next_tag_q + LBL_W'(1);
						if (seed_last) begin
							seed_index_q <= '0;
							state_q      <= ST_EMIT_RD;
						end else begin
							seed_index_q <= next_seed;
							state_q      <= ST_SEED_RD;
						end
					end else begin
						scan_index_q <= next_scan;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_CAP;
				end
				ST_EMIT_CAP: begin
					if (out_free) begin
						if (emit_last) begin
							point_count_q <= '0;
							state_q       <= ST_LOAD;
						end else begin
							seed_index_q <= seed_index_q + IDX_W'(1);
							state_q      <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign emit.valid      = (state_q == ST_EMIT_CAP) && out_free;
	assign emit.label      = lbl_rdata;
	assign emit.final_beat = emit_last;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		point_count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_scan_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, scan_index_q} < point_count_q))
		else $error("scan index outside stored set");

	a_tag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> ({1'b0, next_tag_q} <= {1'b0, point_count_q}))
		else $error("more tags than points");

	a_no_write_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_CAP) |-> !lbl_we && !pos_we)
		else $error("store written while labels are read out");

	a_nonempty_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && $past(state_q) == ST_LOAD && in_beat && last_point)
		|=> (point_count_q != '0))
		else $error("clustering started on an empty set");
`endif

endmodule

// ===== rtl/core/greedy_1d_leader_clustering_core.sv =====
// Greedy 1-D leader clustering core.
// Input channel (in_valid/in_ready): one beat per point, carrying a signed
// Q16.16 position, a preset label (-1 = unassigned) and last_point. Up to 64
// points are stored; beats beyond that are dropped. A beat with last_point
// set closes the set and starts clustering; in_ready stays low until every
// label of the set has been handed to the output register.
// Clustering visits each seed (ascending or descending index, per
// seed_ascending), and an unassigned seed then scans the points after it
// in visiting order at one compare per cycle through a single shared
// distance unit.
// Output channel (out_valid/out_ready): one beat per stored point in index
// order, final_label set on the last; each label is read through the
// registered label memory port. Loading of a following set may begin while the final
// beat still waits. When the receiver stalls, the sequencer holds.
// Configuration (cfg_write/cfg_index/cfg_data) is to be written only while idle;
// the core does not enforce this. Index 0 = distance_limit, index 1 = seed_ascending.
// Reset (arst_n low): store empties, distance_limit = 6554, seed_ascending = 1.
module greedy_1d_leader_clustering_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [g1lc_pkg::POS_W-1:0]     position,
	input  logic signed [g1lc_pkg::LBL_W-1:0]     preset_label,
	input  logic                                  last_point,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [g1lc_pkg::LBL_W-1:0]     cluster_label,
	output logic                                  final_label,
	input  logic                                  cfg_write,
	input  logic        [g1lc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [g1lc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import g1lc_pkg::*;

	cfg_t             cfg_q;
	emit_t            emit;
	logic             out_free;
	logic             out_valid_q;
	logic [LBL_W-1:0] cluster_label_q;
	logic             final_label_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.distance_limit <= LIMIT_RESET;
			cfg_q.seed_ascending <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DISTANCE_LIMIT: cfg_q.distance_limit <= cfg_data[LIM_W-1:0];
				REG_SEED_ASCENDING: cfg_q.seed_ascending <= cfg_data[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	g1lc_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.position     (position),
		.preset_label (preset_label),
		.last_point   (last_point),
		.cfg          (cfg_q),
		.out_free     (out_free),
		.emit         (emit)
	);

	// hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			cluster_label_q <= emit.label;
			final_label_q   <= emit.final_beat;
		end
	end

	assign out_valid     = out_valid_q;
	assign cluster_label = signed'(cluster_label_q);
	assign final_label   = final_label_q;

endmodule

// ===== test/greedy_1d_leader_clustering_core_test.sv =====
module greedy_1d_leader_clustering_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import g1lc_pkg::*;

	typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   sel;
		logic [POS_W-1:0]       value;
		logic [LBL_W-1:0]       preset;
		logic                   last;
		logic                   typed;
		logic [LBL_W-1:0]       want;
	} row_t;

	typedef struct {
		logic [LBL_W-1:0] label;
		logic             final_beat;
	} label_beat_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic signed [POS_W-1:0]      position;
	logic signed [LBL_W-1:0]      preset_label;
	logic                         last_point;
	logic                         out_valid;
	logic                         out_ready;
	logic signed [LBL_W-1:0]      cluster_label;
	logic                         final_label;
	logic                         cfg_write;
	logic [CFG_IDX_W-1:0]         cfg_index;
	logic [CFG_DATA_W-1:0]        cfg_data;

	row_t             plan[24];
	label_beat_t      pending_labels[$];
	logic [POS_W-1:0] set_pos[MAX_POINTS];
	logic [LBL_W-1:0] set_preset[MAX_POINTS];
	logic [LBL_W-1:0] set_want[MAX_POINTS];
	logic             set_typed[MAX_POINTS];
	int               set_count;
	logic [LIM_W-1:0] limit_now;
	logic             ascending_now;
	int               mismatches;
	int               gap_pct;
	int               stall_pct;
	logic             calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	greedy_1d_leader_clustering_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.position     (position),
		.preset_label (preset_label),
		.last_point   (last_point),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cluster_label(cluster_label),
		.final_label  (final_label),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	function automatic row_t point_row(logic [POS_W-1:0] p, logic [LBL_W-1:0] lbl, logic last,
			logic typed, logic [LBL_W-1:0] want);
		row_t row;
		row = '{ROW_POINT, REG_DISTANCE_LIMIT, p, lbl, last, typed, want};
		return row;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] sel, logic [POS_W-1:0] v);
		row_t row;
		row = '{ROW_CFG, sel, v, LBL_UNASSIGNED, 1'b0, 1'b0, LBL_UNASSIGNED};
		return row;
	endfunction

	function automatic void assign_tags();
		logic [LBL_W-1:0] tag_of[MAX_POINTS];
		logic [LBL_W-1:0] tag;
		logic signed [POS_W:0] diff;
		logic [POS_W:0] mag;
		label_beat_t beat;
		int s;
		int j;
		int k;
		int step;
		for (k = 0; k < set_count; k++)
			tag_of[k] = set_preset[k];
		tag = '0;
		for (k = 0; k < set_count; k++) begin
			s = ascending_now ? k : set_count - 1 - k;
			if (tag_of[s] == LBL_UNASSIGNED) begin
				tag_of[s] = tag;
				for (step = 1; step < set_count; step++) begin
					j = ascending_now ? s + step : s - step;
					if (j < 0 || j >= set_count)
						break;
					diff = $signed({set_pos[j][POS_W-1], set_pos[j]}) -
						$signed({set_pos[s][POS_W-1], set_pos[s]});
					mag = diff[POS_W] ? (POS_W+1)'(-diff) : (POS_W+1)'(diff);
					if (tag_of[j] == LBL_UNASSIGNED && mag < {2'b00, limit_now})
						tag_of[j] = tag;
				end
				tag = tag + 1'b1;
			end
		end
		for (k = 0; k < set_count; k++) begin
			beat.label      = set_typed[k] ? set_want[k] : tag_of[k];
			beat.final_beat = (k == set_count - 1);
			pending_labels.insert(pending_labels.size(), beat);
		end
		set_count = 0;
	endfunction

	task automatic send_point(logic [POS_W-1:0] p, logic [LBL_W-1:0] lbl, logic last,
			logic typed, logic [LBL_W-1:0] want);
		in_valid     <= 1'b1;
		position     <= p;
		preset_label <= lbl;
		last_point   <= last;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		if (set_count < MAX_POINTS) begin
			set_pos[set_count]    = p;
			set_preset[set_count] = lbl;
			set_typed[set_count]  = typed;
			set_want[set_count]   = want;
			set_count++;
		end
		if (last)
			assign_tags();
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (pending_labels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [POS_W-1:0] v);
		in_valid <= 1'b0;
		drain();
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= v[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		if (sel == REG_DISTANCE_LIMIT)
			limit_now = v[LIM_W-1:0];
		else
			ascending_now = v[0];
	endtask

	initial begin
		int sent;
		int size;
		int k;
		int r;
		logic [POS_W-1:0] centre;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] prev;
		logic [POS_W-1:0] span;
		logic [POS_W-1:0] off;
		logic [LBL_W-1:0] lbl;
		logic [POS_W-1:0] lim_pick;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		position      = '0;
		preset_label  = '0;
		last_point    = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = REG_DISTANCE_LIMIT;
		cfg_data      = '0;
		set_count     = 0;
		mismatches    = 0;
		limit_now     = LIMIT_RESET;
		ascending_now = 1'b1;
		gap_pct       = 30;
		stall_pct     = 30;
		calm          = 1'b0;

		plan[0]  = point_row(32'h0000_0000, LBL_UNASSIGNED, 1'b1, 1'b1, 7'd0);
		plan[1]  = point_row(32'h7FFF_FFFF, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd0);
		plan[2]  = point_row(32'h8000_0000, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd1);
		plan[3]  = point_row(32'h7FFF_E666, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd0);
		plan[4]  = point_row(32'h7FFF_E665, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd2);
		plan[5]  = point_row(32'h0000_0000, 7'd63, 1'b0, 1'b1, 7'd63);
		plan[6]  = point_row(32'h0000_0005, 7'h40, 1'b0, 1'b1, 7'h40);
		plan[7]  = point_row(32'h0000_0001, 7'd0, 1'b0, 1'b1, 7'd0);
		plan[8]  = point_row(32'h0000_0002, LBL_UNASSIGNED, 1'b1, 1'b1, 7'd3);
		plan[9]  = reg_row(REG_DISTANCE_LIMIT, 32'd0);
		plan[10] = point_row(32'h0000_0000, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd0);
		plan[11] = point_row(32'h0000_0000, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd1);
		plan[12] = point_row(32'h0000_0000, LBL_UNASSIGNED, 1'b1, 1'b1, 7'd2);
		plan[13] = reg_row(REG_DISTANCE_LIMIT, 32'h7FFF_FFFF);
		plan[14] = reg_row(REG_SEED_ASCENDING, 32'd0);
		plan[15] = point_row(32'h7FFF_FFFF, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd0);
		plan[16] = point_row(32'h8000_0000, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd1);
		plan[17] = point_row(32'h0000_0000, LBL_UNASSIGNED, 1'b0, 1'b1, 7'd0);
		plan[18] = point_row(32'h7FFF_FFFE, LBL_UNASSIGNED, 1'b1, 1'b1, 7'd0);
		plan[19] = reg_row(REG_DISTANCE_LIMIT, 32'(LIMIT_RESET));
		plan[20] = reg_row(REG_SEED_ASCENDING, 32'd1);
		plan[21] = point_row(32'd100, LBL_UNASSIGNED, 1'b0, 1'b0, 7'd0);
		plan[22] = point_row(32'd3000, LBL_UNASSIGNED, 1'b0, 1'b0, 7'd0);
		plan[23] = point_row(-32'sd3000, LBL_UNASSIGNED, 1'b1, 1'b0, 7'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].sel, plan[i].value);
			else
				send_point(plan[i].value, plan[i].preset, plan[i].last, plan[i].typed,
					plan[i].want);
		end

		sent = 0;
		while (sent < 480) begin
			if (sent >= 400)
				calm = 1'b1;
			r = $urandom_range(0, 2);
			gap_pct   = (r == 0) ? 0 : (r == 1) ? 25 : 50;
			r = $urandom_range(0, 2);
			stall_pct = (r == 0) ? 0 : (r == 1) ? 20 : 50;
			if (!calm && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 6))
					0:       lim_pick = 32'd0;
					1:       lim_pick = 32'd1;
					2:       lim_pick = 32'(LIMIT_RESET);
					3:       lim_pick = 32'h7FFF_FFFF;
					4:       lim_pick = $urandom_range(1, 1000);
					5:       lim_pick = $urandom_range(1000, 5000000);
					default: lim_pick = $urandom;
				endcase
				write_reg(REG_DISTANCE_LIMIT, lim_pick);
				write_reg(REG_SEED_ASCENDING, $urandom_range(0, 1));
			end else if ($urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				drain();
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				size = $urandom_range(62, 68);
			else if (r <= 4)
				size = $urandom_range(13, 40);
			else
				size = $urandom_range(1, 12);
			centre = $urandom;
			prev   = centre;
			span   = (limit_now < 31'd1000000) ? 32'(limit_now) * 3 + 2 : 32'hFFFF_FFFF;
			for (k = 0; k < size; k++) begin
				r = $urandom_range(0, 9);
				if (r < 7) begin
					off = $urandom_range(0, span);
					p   = $urandom_range(0, 1) ? centre + off : centre - off;
				end else if (r == 7) begin
					p = $urandom;
				end else if (r == 8) begin
					case ($urandom_range(0, 3))
						0:       p = 32'h7FFF_FFFF;
						1:       p = 32'h8000_0000;
						2:       p = 32'h0000_0000;
						default: p = 32'hFFFF_FFFF;
					endcase
				end else begin
					p = $urandom_range(0, 1) ? prev + 32'(limit_now) :
						prev - 32'(limit_now) + 1;
				end
				lbl = ($urandom_range(0, 9) < 8) ? LBL_UNASSIGNED : LBL_W'($urandom);
				send_point(p, lbl, k == size - 1, 1'b0, 7'd0);
				prev = p;
				sent++;
			end
		end

		in_valid <= 1'b0;
		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("greedy_1d_leader_clustering_core: match");
		else
			$display("greedy_1d_leader_clustering_core: mismatch");
		$finish;
	end

	initial begin
		int stall_left;
		label_beat_t want_beat;
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				if (pending_labels.size() == 0) begin
					mismatches++;
					$display("%0t: label beat with none expected, expected nothing, got %0d",
						$time, cluster_label);
				end else begin
					want_beat = pending_labels.pop_front();
					if (cluster_label !== want_beat.label) begin
						mismatches++;
						$display("%0t: cluster_label expected %0d, got %0d", $time,
							$signed(want_beat.label), cluster_label);
					end
					if (final_label !== want_beat.final_beat) begin
						mismatches++;
						$display("%0t: final_label expected %0b, got %0b", $time,
							want_beat.final_beat, final_label);
					end
				end
			end
			if (stall_left > 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 6);
			out_ready <= (stall_left == 0);
		end
	end

	initial begin
		#2_000_000;
		$display("greedy_1d_leader_clustering_core: mismatch");
		$finish;
	end

endmodule
